>>> rtl/psce_pkg.sv
package psce_pkg;

  // Register reset value and field widths.
  localparam logic [15:0] DATA_LENGTH_RESET = 16'd1024;
  localparam int unsigned TERM_W = 18;

  // Depth of the queue between the front and the back part.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Class of a sample as decided by the front part.
  typedef enum logic [1:0] {
    KIND_PILOT = 2'b00,
    KIND_LAST  = 2'b01,
    KIND_DATA  = 2'b10
  } kind_e;

  // One queue entry: the class and either the de-rotated pilot terms
  // (unhalved) or the sign-extended data sample.
  typedef struct packed {
    kind_e                     kind;
    logic signed [TERM_W-1:0]  term_r;
    logic signed [TERM_W-1:0]  term_i;
  } entry_t;

endpackage

>>> rtl/psce_front.sv
module psce_front #(
  parameter int unsigned PILOT_LEN = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic signed [15:0]  sample_i_i,
  input  logic signed [15:0]  sample_q_i,
  output logic                in_stall_o,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                full_i,
  output logic                push_o,
  output psce_pkg::entry_t    entry_o
);

  localparam int unsigned PCW = $clog2(PILOT_LEN);
  localparam logic [PCW-1:0] PILOT_LAST = PCW'(PILOT_LEN - 1);

  // Positions within the four-symbol pilot pattern.
  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;

  logic [15:0]    data_len_q;
  logic           in_data_q, in_data_d;
  logic [PCW-1:0] pilot_cnt_q, pilot_cnt_d;
  logic [15:0]    data_cnt_q, data_cnt_d;
  logic [16:0]    data_cnt_inc;
  logic           accept;

  logic signed [psce_pkg::TERM_W-1:0] xs, ys;
  logic signed [psce_pkg::TERM_W-1:0] tr, ti;

  assign accept     = in_valid_i && !full_i;
  assign in_stall_o = full_i;
  assign push_o     = accept;

  assign xs = {{2{sample_i_i[15]}}, sample_i_i};
  assign ys = {{2{sample_q_i[15]}}, sample_q_i};

  // Multiply by the conjugate of the pilot symbol (halving is done later).
  always_comb begin
    case (pilot_cnt_q[1:0])
      POS_FIRST, POS_SECOND: begin
        tr = xs - ys;
        ti = ys + xs;
      end
      POS_THIRD: begin
        tr = xs + ys;
        ti = ys - xs;
      end
      default: begin
        tr = -xs - ys;
        ti = xs - ys;
      end
    endcase
  end

  assign data_cnt_inc = {1'b0, data_cnt_q} + 17'd1;

  // Frame tracking and classification of the accepted sample.
  always_comb begin
    in_data_d    = in_data_q;
    pilot_cnt_d  = pilot_cnt_q;
    data_cnt_d   = data_cnt_q;
    entry_o.kind   = psce_pkg::KIND_PILOT;
    entry_o.term_r = tr;
    entry_o.term_i = ti;
    if (in_data_q) begin
      entry_o.kind   = psce_pkg::KIND_DATA;
      entry_o.term_r = xs;
      entry_o.term_i = ys;
      if (accept) begin
        if (data_cnt_inc >= {1'b0, data_len_q}) begin
          data_cnt_d = '0;
          in_data_d  = 1'b0;
        end else begin
          data_cnt_d = data_cnt_inc[15:0];
        end
      end
    end else if (pilot_cnt_q == PILOT_LAST) begin
      entry_o.kind = psce_pkg::KIND_LAST;
      if (accept) begin
        pilot_cnt_d = '0;
        data_cnt_d  = '0;
        in_data_d   = (data_len_q != 16'd0);
      end
    end else if (accept) begin
      pilot_cnt_d = pilot_cnt_q + PCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_len_q  <= psce_pkg::DATA_LENGTH_RESET;
      in_data_q   <= 1'b0;
      pilot_cnt_q <= '0;
      data_cnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        data_len_q <= cfg_data_i;
      end
      in_data_q   <= in_data_d;
      pilot_cnt_q <= pilot_cnt_d;
      data_cnt_q  <= data_cnt_d;
    end
  end

endmodule

>>> rtl/psce_queue.sv
module psce_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  psce_pkg::entry_t  entry_i,
  input  logic              pop_i,
  output psce_pkg::entry_t  entry_o,
  output logic              full_o,
  output logic              avail_o
);

  localparam logic [psce_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
    psce_pkg::QUEUE_PTR_W'(psce_pkg::QUEUE_DEPTH - 1);
  localparam logic [psce_pkg::QUEUE_PTR_W-1:0] PTR_ONE =
    psce_pkg::QUEUE_PTR_W'(1);
  localparam logic [psce_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
    psce_pkg::QUEUE_CNT_W'(psce_pkg::QUEUE_DEPTH);
  localparam logic [psce_pkg::QUEUE_CNT_W-1:0] CNT_ONE =
    psce_pkg::QUEUE_CNT_W'(1);

  psce_pkg::entry_t slots_q [psce_pkg::QUEUE_DEPTH];

  logic [psce_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [psce_pkg::QUEUE_CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_FULL);
  assign avail_o = (count_q != '0);
  assign entry_o = slots_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_ONE;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_ONE;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_ONE;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_ONE;
      end
    end
  end

endmodule

>>> rtl/psce_back.sv
module psce_back #(
  parameter int unsigned PILOT_LEN = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                avail_i,
  input  psce_pkg::entry_t    entry_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [15:0]  out_i_o,
  output logic signed [15:0]  out_q_o,
  output logic                is_estimate_o,
  output logic [31:0]         estimate_power_o
);

  // The accumulator starts at an offset that makes it non-negative and folds
  // in the rounding term, so the mean is a plain floor division.
  localparam int unsigned DEN   = 2 * PILOT_LEN;
  localparam int unsigned VW    = $clog2(PILOT_LEN) + 18;
  localparam int unsigned KW    = $clog2(DEN);
  localparam int unsigned SHIFT = VW + KW;
  localparam int unsigned MW    = VW + 2;
  localparam int unsigned PW    = VW + MW;
  localparam logic [63:0] RECIP = ((64'd1 << SHIFT) + 64'(DEN) - 64'd1) / 64'(DEN);
  localparam logic [VW-1:0] OFFSET = VW'(PILOT_LEN * 65537);
  localparam int unsigned EXT = VW - psce_pkg::TERM_W;

  logic adv;

  logic [VW-1:0] acc_r_q, acc_r_d, acc_i_q, acc_i_d;
  logic [VW-1:0] sum_r, sum_i;

  logic          s1_valid_q, s1_valid_d, s1_est_q;
  logic [15:0]   s1_di_q, s1_dq_q;
  logic [VW-1:0] s1_vr_q, s1_vi_q;

  logic          s2_valid_q, s2_est_q;
  logic [15:0]   s2_di_q, s2_dq_q;
  logic [16:0]   s2_qr_q, s2_qi_q;
  logic [PW-1:0] prod_r, prod_i;

  logic               s3_valid_q, s3_est_q;
  logic signed [15:0] s3_oi_q, s3_oq_q, s3_oi_d, s3_oq_d;
  logic signed [15:0] est_r, est_i;

  logic               s4_valid_q, s4_est_q;
  logic signed [15:0] s4_oi_q, s4_oq_q;
  logic [30:0]        s4_sqr_q, s4_sqi_q;
  logic signed [31:0] sq_r, sq_i;

  logic               out_valid_q, out_est_q;
  logic signed [15:0] out_i_q, out_q_q;
  logic [31:0]        out_pw_q, out_pw_d;

  // The whole back pipeline moves unless a result is held by the receiver.
  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = adv && avail_i;

  assign sum_r = acc_r_q + {{EXT{entry_i.term_r[psce_pkg::TERM_W-1]}}, entry_i.term_r};
  assign sum_i = acc_i_q + {{EXT{entry_i.term_i[psce_pkg::TERM_W-1]}}, entry_i.term_i};

  // Accumulation of the pilot terms.
  always_comb begin
    acc_r_d    = acc_r_q;
    acc_i_d    = acc_i_q;
    s1_valid_d = 1'b0;
    if (pop_o) begin
      case (entry_i.kind)
        psce_pkg::KIND_PILOT: begin
          acc_r_d = sum_r;
          acc_i_d = sum_i;
        end
        psce_pkg::KIND_LAST: begin
          acc_r_d    = OFFSET;
          acc_i_d    = OFFSET;
          s1_valid_d = 1'b1;
        end
        psce_pkg::KIND_DATA: begin
          s1_valid_d = 1'b1;
        end
        default: begin
          s1_valid_d = 1'b0;
        end
      endcase
    end
  end

  // Division by twice the pilot length through a reciprocal multiply.
  assign prod_r = PW'(s1_vr_q) * PW'(RECIP[MW-1:0]);
  assign prod_i = PW'(s1_vi_q) * PW'(RECIP[MW-1:0]);

  // Remove the offset and clamp to the sample range.
  assign est_r   = s2_qr_q[16] ? 16'sh7FFF : {~s2_qr_q[15], s2_qr_q[14:0]};
  assign est_i   = s2_qi_q[16] ? 16'sh7FFF : {~s2_qi_q[15], s2_qi_q[14:0]};
  assign s3_oi_d = s2_est_q ? est_r : s2_di_q;
  assign s3_oq_d = s2_est_q ? est_i : s2_dq_q;

  // Power of the estimate.
  assign sq_r     = s3_oi_q * s3_oi_q;
  assign sq_i     = s3_oq_q * s3_oq_q;
  assign out_pw_d = s4_est_q ? ({1'b0, s4_sqr_q} + {1'b0, s4_sqi_q}) : 32'd0;

  // Control state and accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_r_q     <= OFFSET;
      acc_i_q     <= OFFSET;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_r_q <= acc_r_d;
      acc_i_q <= acc_i_d;
      if (adv) begin
        s1_valid_q  <= s1_valid_d;
        s2_valid_q  <= s1_valid_q;
        s3_valid_q  <= s2_valid_q;
        s4_valid_q  <= s3_valid_q;
        out_valid_q <= s4_valid_q;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_est_q  <= (entry_i.kind == psce_pkg::KIND_LAST);
      s1_di_q   <= entry_i.term_r[15:0];
      s1_dq_q   <= entry_i.term_i[15:0];
      s1_vr_q   <= sum_r;
      s1_vi_q   <= sum_i;

      s2_est_q  <= s1_est_q;
      s2_di_q   <= s1_di_q;
      s2_dq_q   <= s1_dq_q;
      s2_qr_q   <= prod_r[SHIFT +: 17];
      s2_qi_q   <= prod_i[SHIFT +: 17];

      s3_est_q  <= s2_est_q;
      s3_oi_q   <= s3_oi_d;
      s3_oq_q   <= s3_oq_d;

      s4_est_q  <= s3_est_q;
      s4_oi_q   <= s3_oi_q;
      s4_oq_q   <= s3_oq_q;
      s4_sqr_q  <= sq_r[30:0];
      s4_sqi_q  <= sq_i[30:0];

      out_est_q <= s4_est_q;
      out_i_q   <= s4_oi_q;
      out_q_q   <= s4_oq_q;
      out_pw_q  <= out_pw_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_i_o          = out_i_q;
  assign out_q_o          = out_q_q;
  assign is_estimate_o    = out_est_q;
  assign estimate_power_o = out_pw_q;

endmodule

>>> rtl/pilot_strip_channel_estimate.sv
// Pilot strip and least-squares channel estimate.
// The input channel (in_valid_i, in_stall_o) takes one complex Q1.15 sample
// per transfer. A frame is PILOT_LEN pilot samples followed by data_length
// data samples; cfg_we_i loads data_length from cfg_data_i and may only be
// used while no sample is in flight.
// The output channel (out_valid_o, out_stall_i) moves one result per transfer:
// a passed-through data sample, or at the last pilot sample the channel
// estimate with is_estimate_o set and its power on estimate_power_o.
// Pilot samples other than the last one produce no result.
// Throughput is one sample per clock cycle while the receiver does not stall.
// A result passes through the four-entry queue and then the accumulate,
// divide, clamp and power stages and the output register of the back pipeline.
// When the receiver stalls, the back pipeline holds and the queue absorbs
// samples until its four entries are full, then in_stall_o rises.
// Reset clears the frame position to the first pilot sample, empties the
// queue and the pipeline, and sets data_length to 1024.
module pilot_strip_channel_estimate #(
  parameter int unsigned PILOT_LEN = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [15:0]  sample_i_i,
  input  logic signed [15:0]  sample_q_i,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [15:0]  out_i_o,
  output logic signed [15:0]  out_q_o,
  output logic                is_estimate_o,
  output logic [31:0]         estimate_power_o
);

  psce_pkg::entry_t push_entry, pop_entry;
  logic push, pop, full, avail;

  // Front part: frame tracking and pilot de-rotation.
  psce_front #(
    .PILOT_LEN (PILOT_LEN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sample_i_i (sample_i_i),
    .sample_q_i (sample_q_i),
    .in_stall_o (in_stall_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  // Queue between the two parts.
  psce_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (pop_entry),
    .full_o  (full),
    .avail_o (avail)
  );

  // Back part: accumulation, estimate and output register.
  psce_back #(
    .PILOT_LEN (PILOT_LEN)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .avail_i          (avail),
    .entry_i          (pop_entry),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_i_o          (out_i_o),
    .out_q_o          (out_q_o),
    .is_estimate_o    (is_estimate_o),
    .estimate_power_o (estimate_power_o)
  );

endmodule
